// ----- design/heightmap_bilinear_sampler_top_defines.svh -----
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler assertion macros
// Concurrent check wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge
`define HBS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
// consequent must hold in the cycle after antecedent
`define HBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: sequence check failed");
`else
`define HBS_ASSERT(lbl, prop)
`define HBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler package
// Shared types, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package hbs_pkg;

	// fixed field widths
	localparam int POS_W     = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int TADDR_W   = 18;
	localparam int CODE_W    = 16;
	localparam int MSIZE_W   = 10;
	// code (17b signed) times rerange scale (32b signed)
	localparam int PROD_W    = 49;
	localparam int SUM_W     = 50;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_U   = 3'd0,
		REG_OFFSET_V   = 3'd1,
		REG_SCALE_U    = 3'd2,
		REG_SCALE_V    = 3'd3,
		REG_MAP_WIDTH  = 3'd4,
		REG_MAP_HEIGHT = 3'd5,
		REG_RR_SCALE   = 3'd6,
		REG_RR_OFFSET  = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [CFG_W-1:0]   SCALE_RESET    = 32'h0100_0000;
	localparam logic [MSIZE_W-1:0] MSIZE_RESET    = 10'd512;
	localparam logic [CFG_W-1:0]   RR_SCALE_RESET = 32'h0001_0000;

	// step strobes for one coordinate unit
	typedef struct packed {
		logic load_d;
		logic load_t;
		logic load_idx;
	} axis_ctl_t;

endpackage

// ----- design/heightmap_bilinear_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler
// Texel store with bilinear elevation queries and linear rerange.
// ----------------------------------------------------------------------------
// A texel write (req_type 0) writes the single-port height memory at once on
// its transfer; addresses at or beyond MAX_WIDTH*MAX_HEIGHT are dropped. A
// query (req_type 1) keeps the input stalled after its transfer until its
// last step is done, in these steps: offset subtract, scale multiply and edge
// clamp, the row base multiply, the four neighbor reads through the one memory
// port, then row blend, column blend, rerange multiply and saturation. The
// result sits in an output register, so the next item is taken while a result
// waits; a query stalls in its last step only while the previous result has
// not been transferred. Texels must be written before a query reads them.
// ----------------------------------------------------------------------------
`include "heightmap_bilinear_sampler_top_defines.svh"

module heightmap_bilinear_sampler_top import hbs_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic [TADDR_W-1:0]      texel_addr,
	input  logic [CODE_W-1:0]       texel_value,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] elevation,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SZ_U   = $clog2(MAX_WIDTH + 1);
	localparam int SZ_V   = $clog2(MAX_HEIGHT + 1);
	localparam int IDX_U  = $clog2(MAX_WIDTH);
	localparam int IDX_V  = $clog2(MAX_HEIGHT);
	localparam int RW     = CODE_W + FRAC_BITS;
	localparam int AW     = CODE_W + 2 * FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [AW-1:0]      HALF = AW'(1) << (2 * FRAC_BITS - 1);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_MUL  = 12'b0000_0000_0010,
		ST_IDX  = 12'b0000_0000_0100,
		ST_BASE = 12'b0000_0000_1000,
		ST_RD0  = 12'b0000_0001_0000,
		ST_RD1  = 12'b0000_0010_0000,
		ST_RD2  = 12'b0000_0100_0000,
		ST_RD3  = 12'b0000_1000_0000,
		ST_ROW  = 12'b0001_0000_0000,
		ST_COL  = 12'b0010_0000_0000,
		ST_RR   = 12'b0100_0000_0000,
		ST_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_nxt;

	// configuration registers
	logic signed [POS_W-1:0] off_u_q, off_v_q;
	logic [CFG_W-1:0]        scale_u_q, scale_v_q;
	logic [MSIZE_W-1:0]      map_width_q, map_height_q;
	logic signed [CFG_W-1:0] rr_scale_q, rr_offset_q;

	// datapath
	logic [SZ_U-1:0]      w_eff;
	logic [SZ_V-1:0]      h_eff;
	axis_ctl_t            axis_ctl;
	logic [IDX_U-1:0]     u0, u1;
	logic [IDX_V-1:0]     v0, v1;
	logic [FRAC_BITS-1:0] fu, fv;
	logic [FRAC_BITS:0]   wfu, wfv;
	logic [ADDR_W-1:0]    base0_q, base1_q;
	logic [CODE_W-1:0]    d00_q, d10_q, d01_q;
	logic [RW-1:0]        r0_q, r1_q;
	logic [AW-1:0]        acc_q;
	logic [CODE_W-1:0]    code;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-9:0]     sh;
	logic signed [POS_W-1:0]  elev_sat;
	logic                 out_valid_q;
	logic signed [POS_W-1:0]  elevation_q;
	logic                 in_xfer, out_xfer, fin_go;

	// memory port
	logic [CODE_W-1:0] mem [DEPTH];
	logic [CODE_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_u_q      <= '0;
			off_v_q      <= '0;
			scale_u_q    <= SCALE_RESET;
			scale_v_q    <= SCALE_RESET;
			map_width_q  <= MSIZE_RESET;
			map_height_q <= MSIZE_RESET;
			rr_scale_q   <= RR_SCALE_RESET;
			rr_offset_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OFFSET_U:   off_u_q      <= cfg_data;
				REG_OFFSET_V:   off_v_q      <= cfg_data;
				REG_SCALE_U:    scale_u_q    <= cfg_data;
				REG_SCALE_V:    scale_v_q    <= cfg_data;
				REG_MAP_WIDTH:  map_width_q  <= cfg_data[MSIZE_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_data[MSIZE_W-1:0];
				REG_RR_SCALE:   rr_scale_q   <= cfg_data;
				REG_RR_OFFSET:  rr_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective map size: zero acts as one, oversize clips to the store
	always_comb begin
		if (map_width_q == '0)
			w_eff = SZ_U'(1);
		else if (32'(map_width_q) > 32'(MAX_WIDTH))
			w_eff = SZ_U'(MAX_WIDTH);
		else
			w_eff = SZ_U'(map_width_q);
		if (map_height_q == '0)
			h_eff = SZ_V'(1);
		else if (32'(map_height_q) > 32'(MAX_HEIGHT))
			h_eff = SZ_V'(MAX_HEIGHT);
		else
			h_eff = SZ_V'(map_height_q);
	end

	// sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_xfer && req_type) state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_IDX;
			ST_IDX:  state_nxt = ST_BASE;
			ST_BASE: state_nxt = ST_RD0;
			ST_RD0:  state_nxt = ST_RD1;
			ST_RD1:  state_nxt = ST_RD2;
			ST_RD2:  state_nxt = ST_RD3;
			ST_RD3:  state_nxt = ST_ROW;
			ST_ROW:  state_nxt = ST_COL;
			ST_COL:  state_nxt = ST_RR;
			ST_RR:   state_nxt = ST_FIN;
			ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// coordinate units: u from world y, v from world x
	assign axis_ctl = '{
		load_d:   in_xfer && req_type,
		load_t:   state_q == ST_MUL,
		load_idx: state_q == ST_IDX
	};

	hbs_axis #(
		.MAX_SIZE  (MAX_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_axis_u (
		.clk    (clk),
		.ctl    (axis_ctl),
		.pos    (pos_y),
		.off    (off_u_q),
		.scale  (scale_u_q),
		.size   (w_eff),
		.idx    (u0),
		.idx1   (u1),
		.frac   (fu)
	);

	hbs_axis #(
		.MAX_SIZE  (MAX_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_axis_v (
		.clk    (clk),
		.ctl    (axis_ctl),
		.pos    (pos_x),
		.off    (off_v_q),
		.scale  (scale_v_q),
		.size   (h_eff),
		.idx    (v0),
		.idx1   (v1),
		.frac   (fv)
	);

	// row base addresses
	always_ff @(posedge clk) begin
		if (state_q == ST_BASE) begin
			base0_q <= ADDR_W'(v0) * ADDR_W'(w_eff);
			base1_q <= ADDR_W'(v1) * ADDR_W'(w_eff);
		end
	end

	// single memory port: writes only while idle, reads during a query
	assign mem_we  = in_xfer && !req_type && (32'(texel_addr) < 32'(DEPTH));
	assign wr_addr = ADDR_W'(texel_addr);
	assign mem_re  = (state_q == ST_RD0) || (state_q == ST_RD1) ||
	                 (state_q == ST_RD2) || (state_q == ST_RD3);

	always_comb begin
		case (state_q)
			ST_RD0:  rd_addr = base0_q + ADDR_W'(u0);
			ST_RD1:  rd_addr = base0_q + ADDR_W'(u1);
			ST_RD2:  rd_addr = base1_q + ADDR_W'(u0);
			ST_RD3:  rd_addr = base1_q + ADDR_W'(u1);
			default: rd_addr = base0_q + ADDR_W'(u0);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= texel_value;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// collect the first three neighbors in the state after each read; the fourth is used straight from the read register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD1:  d00_q <= rd_data_q;
			ST_RD2:  d10_q <= rd_data_q;
			ST_RD3:  d01_q <= rd_data_q;
			default: ;
		endcase
	end

	// blend along u, then along v with the rounding half folded in
	assign wfu = ONE - {1'b0, fu};
	assign wfv = ONE - {1'b0, fv};

	always_ff @(posedge clk) begin
		if (state_q == ST_ROW) begin
			r0_q <= RW'(d00_q) * RW'(wfu) + RW'(d10_q) * RW'(fu);
			r1_q <= RW'(d01_q) * RW'(wfu) + RW'(rd_data_q) * RW'(fu);
		end
		if (state_q == ST_COL) begin
			acc_q <= AW'(r0_q) * AW'(wfv) + AW'(r1_q) * AW'(fv) + HALF;
		end
	end

	// rerange multiply
	assign code = acc_q[2*FRAC_BITS +: CODE_W];

	always_ff @(posedge clk) begin
		if (state_q == ST_RR) begin
			prod_q <= PROD_W'($signed({1'b0, code})) * PROD_W'(rr_scale_q);
		end
	end

	// offset, round half up to Q24.8, saturate
	assign sum = $signed({prod_q[PROD_W-1], prod_q})
	           + $signed({{(SUM_W-CFG_W-8){rr_offset_q[CFG_W-1]}}, rr_offset_q, 8'd0})
	           + $signed(SUM_W'(128));
	assign sh  = sum[SUM_W-1:8];

	always_comb begin
		if ((&sh[SUM_W-9:POS_W-1]) || !(|sh[SUM_W-9:POS_W-1]))
			elev_sat = sh[POS_W-1:0];
		else if (sh[SUM_W-9])
			elev_sat = {1'b1, {(POS_W-1){1'b0}}};
		else
			elev_sat = {1'b0, {(POS_W-1){1'b1}}};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			elevation_q <= elev_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign elevation = elevation_q;

	// checks
	`HBS_ASSERT_NEXT(a_query_starts, in_valid && !in_stall && req_type, state_q == ST_MUL)
	`HBS_ASSERT_NEXT(a_fin_loads_out, fin_go, out_valid_q && (state_q == ST_IDLE))
	`HBS_ASSERT(a_port_exclusive, !(mem_we && mem_re))

endmodule

// ----- design/hbs_axis.sv -----
// ----------------------------------------------------------------------------
// Heightmap sampler coordinate unit
// Maps one world coordinate to a clamped texel index, neighbor and fraction
// in three registered steps: offset subtract, scale multiply, edge clamp.
// ----------------------------------------------------------------------------
module hbs_axis import hbs_pkg::*; #(
	parameter int MAX_SIZE  = 512,
	parameter int FRAC_BITS = 16,
	localparam int SZ_W     = $clog2(MAX_SIZE + 1),
	localparam int IDX_W    = $clog2(MAX_SIZE)
) (
	input  logic                    clk,
	input  axis_ctl_t               ctl,
	input  logic signed [POS_W-1:0] pos,
	input  logic signed [POS_W-1:0] off,
	input  logic [CFG_W-1:0]        scale,
	input  logic [SZ_W-1:0]         size,
	output logic [IDX_W-1:0]        idx,
	output logic [IDX_W-1:0]        idx1,
	output logic [FRAC_BITS-1:0]    frac
);

	logic signed [POS_W:0] d_q;
	logic [2*CFG_W-1:0]    t_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      idx1_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic                  d_pos;
	logic [CFG_W-1:0]      t_hi;
	logic [CFG_W-1:0]      lim;
	logic                  at_edge;

	// exact difference, 33 bits
	always_ff @(posedge clk) begin
		if (ctl.load_d) begin
			d_q <= {pos[POS_W-1], pos} - {off[POS_W-1], off};
		end
	end

	// Q.32 texel position; non-positive offsets map to zero
	assign d_pos = !d_q[POS_W] && (|d_q[POS_W-1:0]);

	always_ff @(posedge clk) begin
		if (ctl.load_t) begin
			t_q <= d_pos ? (2*CFG_W)'(d_q[POS_W-1:0]) * (2*CFG_W)'(scale) : '0;
		end
	end

	// clamp at the far edge; below it the neighbor is index plus one
	assign t_hi    = t_q[2*CFG_W-1:CFG_W];
	assign lim     = CFG_W'(size) - 32'd1;
	assign at_edge = (t_hi >= lim);

	always_ff @(posedge clk) begin
		if (ctl.load_idx) begin
			idx_q  <= at_edge ? IDX_W'(lim) : IDX_W'(t_hi);
			idx1_q <= at_edge ? IDX_W'(lim) : IDX_W'(t_hi + 32'd1);
			frac_q <= at_edge ? '0 : t_q[CFG_W-1 -: FRAC_BITS];
		end
	end

	assign idx  = idx_q;
	assign idx1 = idx1_q;
	assign frac = frac_q;

endmodule
